/* sv/oaht_pkg.sv */
// Package for the open-addressing hash table: slot layout, mark, operation
// and status codes, sequencer state type and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package oaht_pkg;

	localparam int KEY_W   = 32;
	localparam int HASH_W  = 32;
	localparam int VAL_W   = 64;
	localparam int LIMIT_W = 7;

	// hash bits folded into the remainder per cycle
	localparam int MOD_STEP  = 4;
	localparam int MOD_ITERS = HASH_W / MOD_STEP;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd48;

	// operation codes
	localparam logic [1:0] OP_GET    = 2'd0;
	localparam logic [1:0] OP_SET    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_ABSENT = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	// slot marks; the unused code reads as a tombstone
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_USED  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]       mark;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_FETCH,
		ST_PROBE
	} seq_state_t;

endpackage

/* sv/oaht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/oaht_mod.sv */
// Serial remainder unit: key_hash modulo CAPACITY, MOD_STEP hash bits per cycle
// by shift, compare and subtract. Depends on oaht_pkg.
`timescale 1ns / 1ps

module oaht_mod
	import oaht_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [HASH_W-1:0]           hash,
	output logic                        done,
	output logic [$clog2(CAPACITY)-1:0] rem
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(MOD_ITERS);
	localparam logic [IDX_W:0] CAP_V = (IDX_W + 1)'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_ITERS - 1);

	logic [HASH_W-1:0] hash_q;
	logic [IDX_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [HASH_W-1:0] hash_nx;
	logic [IDX_W-1:0]  rem_nx;

	// fold MOD_STEP hash bits into the running remainder
	always_comb begin
		logic [IDX_W:0] wide;
		hash_nx = hash_q;
		rem_nx  = rem_q;
		for (int i = 0; i < MOD_STEP; i++) begin
			wide    = {rem_nx, hash_nx[HASH_W-1]};
			hash_nx = {hash_nx[HASH_W-2:0], 1'b0};
			if (wide >= CAP_V) begin
				wide = wide - CAP_V;
			end
			rem_nx = wide[IDX_W-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q  <= cnt_q + 1'b1;
			run_q  <= (cnt_q != CNT_LAST);
			done_q <= (cnt_q == CNT_LAST);
		end else begin
			done_q <= 1'b0;
		end
	end

	// operand and remainder
	always_ff @(posedge clk) begin
		if (load) begin
			hash_q <= hash;
			rem_q  <= '0;
		end else if (run_q) begin
			hash_q <= hash_nx;
			rem_q  <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* sv/open_address_hash_table.sv */
// Top level of the open-addressing hash table: sequencer, probe logic, slot
// memory and used count. Depends on oaht_pkg, oaht_ram and oaht_mod.
//
// Usage: pulse start with operation, key, key_hash and value while busy is
// low; in the cycle after a transaction ends, done is high for exactly one cycle
// with status, is_new and value_out, and the receiver cannot stall it. The
// slot memory gives one probe per cycle, and a get, set or remove probes from
// 1 to CAPACITY slots. When CAPACITY is a power of two the low key_hash bits
// give the first slot; otherwise the serial modulo unit first reduces key_hash.
// A set refused at the load limit and an unknown operation code are answered
// from idle with no probe. After reset the block clears the slot marks,
// one slot per cycle, with busy high until all are clear; load_limit may be
// written in any cycle, including during that pass, and is only looked at
// when a set is accepted.
`timescale 1ns / 1ps

module open_address_hash_table
	import oaht_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [KEY_W-1:0]   key,
	input  logic [HASH_W-1:0]  key_hash,
	input  logic [VAL_W-1:0]   value,
	input  logic               load_limit_we,
	input  logic [LIMIT_W-1:0] load_limit,
	output logic               done,
	output logic [1:0]         status,
	output logic               is_new,
	output logic [VAL_W-1:0]   value_out
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
	localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

	seq_state_t state_q, state_d;

	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   n_q;
	logic [IDX_W-1:0]   tomb_q;
	logic               have_tomb_q;
	logic [CNT_W-1:0]   used_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               done_q;
	logic [1:0]         status_q;
	logic               is_new_q;
	logic [VAL_W-1:0]   value_out_q;
	logic [1:0]         op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;

	logic               accept;
	logic               over_limit;
	logic               op_valid;
	logic               mod_done;
	logic [IDX_W-1:0]   mod_rem;
	logic [IDX_W-1:0]   idx_nx;

	// probe decode
	slot_t              rd_slot;
	logic               is_empty;
	logic               is_hit;
	logic               is_tomb;
	logic               probe_last;
	logic               fin;

	// memory port and result
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	slot_t              ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic               res_valid;
	logic [1:0]         res_status;
	logic               res_is_new;
	logic [VAL_W-1:0]   res_value;
	logic               used_inc;

	oaht_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_slot)
	);

	oaht_mod #(
		.CAPACITY (CAPACITY)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.hash   (key_hash),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// transaction acceptance and set limit check
	assign accept     = start && (state_q == ST_IDLE);
	assign over_limit = (CMP_W'(used_q) + CMP_W'(1)) > CMP_W'(limit_q);
	assign op_valid   = (operation == OP_GET) || (operation == OP_SET) ||
		(operation == OP_REMOVE);
	assign idx_nx     = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;

	// probe decode of the slot read last cycle
	assign is_empty   = (rd_slot.mark == MARK_EMPTY);
	assign is_hit     = (rd_slot.mark == MARK_USED) && (rd_slot.key == key_q);
	assign is_tomb    = !is_empty && (rd_slot.mark != MARK_USED);
	assign probe_last = (n_q == IDX_LAST);
	assign fin        = is_empty || is_hit || probe_last;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && op_valid && !((operation == OP_SET) && over_limit)) begin
					state_d = IS_POW2 ? ST_FETCH : ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory port, result and count update
	always_comb begin
		logic             have_slot;
		logic [IDX_W-1:0] slot_idx;
		have_slot  = is_empty || is_hit || have_tomb_q || is_tomb;
		slot_idx   = (!is_hit && have_tomb_q) ? tomb_q : idx_q;
		ram_we     = 1'b0;
		ram_waddr  = slot_idx;
		ram_wdata  = '{mark: MARK_USED, key: key_q, value: val_q};
		ram_raddr  = (state_q == ST_PROBE) ? idx_nx : idx_q;
		res_valid  = 1'b0;
		res_status = STAT_ABSENT;
		res_is_new = 1'b0;
		res_value  = '0;
		used_inc   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '{mark: MARK_EMPTY, key: '0, value: '0};
			end
			ST_IDLE: begin
				// refused set or unknown code answers at once
				if (start && (!op_valid || ((operation == OP_SET) && over_limit))) begin
					res_valid  = 1'b1;
					res_status = (operation == OP_SET) ? STAT_FULL : STAT_ABSENT;
				end
			end
			ST_PROBE: begin
				if (fin) begin
					res_valid = 1'b1;
					case (op_q)
						OP_GET: begin
							if (is_hit) begin
								res_status = STAT_OK;
								res_value  = rd_slot.value;
							end
						end
						OP_SET: begin
							if (have_slot) begin
								ram_we     = 1'b1;
								res_status = STAT_OK;
								res_is_new = !is_hit;
								used_inc   = !is_hit && is_empty && !have_tomb_q;
							end else begin
								res_status = STAT_FULL;
							end
						end
						OP_REMOVE: begin
							if (is_hit) begin
								ram_we     = 1'b1;
								ram_waddr  = idx_q;
								ram_wdata  = '{mark: MARK_TOMB, key: rd_slot.key,
									value: rd_slot.value};
								res_status = STAT_OK;
							end
						end
						default: begin
							res_status = STAT_ABSENT;
						end
					endcase
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			n_q         <= '0;
			have_tomb_q <= 1'b0;
			used_q      <= '0;
			limit_q     <= LIMIT_RESET;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_limit_we) begin
				limit_q <= load_limit;
			end
			if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
			if (state_q == ST_FETCH) begin
				n_q         <= '0;
				have_tomb_q <= 1'b0;
			end else if ((state_q == ST_PROBE) && !fin) begin
				n_q <= n_q + 1'b1;
				if (is_tomb) begin
					have_tomb_q <= 1'b1;
				end
			end
		end
	end

	// transaction payload, probe position and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			key_q <= key;
			val_q <= value;
			idx_q <= key_hash[IDX_W-1:0];
		end else if ((state_q == ST_MOD) && mod_done) begin
			idx_q <= mod_rem;
		end else if ((state_q == ST_PROBE) && !fin) begin
			idx_q <= idx_nx;
			if (is_tomb && !have_tomb_q) begin
				tomb_q <= idx_q;
			end
		end
		if (res_valid) begin
			status_q    <= res_status;
			is_new_q    <= res_is_new;
			value_out_q <= res_value;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign is_new    = is_new_q;
	assign value_out = value_out_q;

endmodule

/* sv/oaht_checker.sv */
// Port-level checker for the open-addressing hash table, bound to the top
// level. Depends on oaht_pkg and open_address_hash_table.
`timescale 1ns / 1ps

module oaht_checker
	import oaht_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [1:0]       status,
	input logic             is_new,
	input logic [VAL_W-1:0] value_out
);

	// a result is only shown once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// an accepted transaction either answers at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither answered nor busy");

	// status is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((status == STAT_OK) || (status == STAT_ABSENT) || (status == STAT_FULL)))
		else $error("undefined status code");

	// a new insertion is always a success
	a_new_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_new) |-> (status == STAT_OK))
		else $error("is_new without success");

	// only a found key returns a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> (value_out == '0))
		else $error("value returned on failure");

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.is_new    (is_new),
	.value_out (value_out)
);
